[hw/rtl/lfd_pkg.sv]
package lfd_pkg;

  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned RES_W       = 7;

  // configuration register indexes
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_STALL_TICKS = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd148;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd195;
  localparam logic [7:0] STALL_TICKS_RST = 8'd2;

  typedef enum logic {
    CMD_BYTE,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P0,
    ST_C0,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_EMIT,
    ST_RSYNC,
    ST_SCAN
  } eng_state_t;

endpackage

[hw/rtl/lfd_front.sv]
module lfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [7:0]        rx_byte,
  output logic              q_valid,
  output lfd_pkg::cmd_t     q_cmd,
  input  logic              q_pop
);

  lfd_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  lfd_pkg::cmd_t cmd_in;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = entries[rd_ptr];

  // classify the transfer into a byte or a tick command
  always_comb begin
    cmd_in.kind = op ? lfd_pkg::CMD_TICK : lfd_pkg::CMD_BYTE;
    cmd_in.data = rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

endmodule

[hw/rtl/lfd_engine.sv]
module lfd_engine #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              q_valid,
  input  lfd_pkg::cmd_t     q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        frame_byte,
  output logic              frame_last,
  output logic [5:0]        payload_length
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] Depth   = SW'(BUF_DEPTH);
  localparam logic [CW-1:0] DepthC  = CW'(BUF_DEPTH);
  localparam logic [15:0]   MaxPlen = 16'(BUF_DEPTH - lfd_pkg::HDR_BYTES);
  localparam logic [CW-1:0] HdrC    = CW'(lfd_pkg::HDR_BYTES);
  localparam logic [lfd_pkg::RES_W-1:0] MaxRes = lfd_pkg::RES_W'(lfd_pkg::MAX_RESULTS);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rdata;

  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [7:0] stall_ticks;

  lfd_pkg::eng_state_t state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] fill, fill_next;
  logic [7:0]    idle_ticks, idle_ticks_next;
  logic [CW-1:0] off, off_next;
  logic [CW-1:0] total, total_next;
  logic [5:0]    plen6, plen6_next;
  logic [7:0]    len_hi, len_hi_next;
  logic [lfd_pkg::RES_W-1:0] res_cnt, res_cnt_next;
  logic          out_valid_next;
  logic          load_out;

  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [15:0]   plen;
  logic [7:0]    tick_inc;
  logic          show;
  logic          advance;
  logic          last_byte;

  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] ofs);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(ofs);
    if (s >= Depth) begin
      s = s - Depth;
    end
    return s[AW-1:0];
  endfunction

  assign plen      = {len_hi, rdata};
  assign tick_inc  = (idle_ticks == 8'hFF) ? idle_ticks : idle_ticks + 8'd1;
  assign waddr     = wrap_addr(head, fill);
  assign show      = (res_cnt < MaxRes);
  assign advance   = !show || !out_valid || !out_stall;
  assign last_byte = ((off + CW'(1)) == total);

  always_comb begin
    state_next      = state;
    head_next       = head;
    fill_next       = fill;
    idle_ticks_next = idle_ticks;
    off_next        = off;
    total_next      = total;
    plen6_next      = plen6;
    len_hi_next     = len_hi;
    res_cnt_next    = res_cnt;
    out_valid_next  = out_valid && out_stall;
    load_out        = 1'b0;
    q_pop           = 1'b0;
    mem_we          = 1'b0;
    raddr           = head;

    unique case (state)
      lfd_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          res_cnt_next = '0;
          if (q_cmd.kind == lfd_pkg::CMD_BYTE) begin
            if (fill < DepthC) begin
              mem_we    = 1'b1;
              fill_next = fill + CW'(1);
            end
            idle_ticks_next = 8'd0;
            state_next      = lfd_pkg::ST_P0;
          end else if (fill == '0) begin
            idle_ticks_next = 8'd0;
          end else if (tick_inc >= stall_ticks) begin
            idle_ticks_next = 8'd0;
            state_next      = lfd_pkg::ST_RSYNC;
          end else begin
            idle_ticks_next = tick_inc;
            state_next      = lfd_pkg::ST_P0;
          end
        end
      end

      lfd_pkg::ST_P0: begin
        if (fill == '0) begin
          idle_ticks_next = 8'd0;
          state_next      = lfd_pkg::ST_IDLE;
        end else begin
          state_next = lfd_pkg::ST_C0;
        end
      end

      lfd_pkg::ST_C0: begin
        if (rdata != sync_first) begin
          state_next = lfd_pkg::ST_RSYNC;
        end else if (fill < CW'(2)) begin
          state_next = lfd_pkg::ST_IDLE;
        end else begin
          raddr      = wrap_addr(head, CW'(1));
          state_next = lfd_pkg::ST_C1;
        end
      end

      lfd_pkg::ST_C1: begin
        if (rdata != sync_second) begin
          state_next = lfd_pkg::ST_RSYNC;
        end else if (fill < HdrC) begin
          state_next = lfd_pkg::ST_IDLE;
        end else begin
          raddr      = wrap_addr(head, CW'(2));
          state_next = lfd_pkg::ST_C2;
        end
      end

      lfd_pkg::ST_C2: begin
        len_hi_next = rdata;
        raddr       = wrap_addr(head, CW'(3));
        state_next  = lfd_pkg::ST_C3;
      end

      lfd_pkg::ST_C3: begin
        if (plen > MaxPlen) begin
          state_next = lfd_pkg::ST_RSYNC;
        end else begin
          total_next = plen[CW-1:0] + HdrC;
          plen6_next = plen[5:0];
          if (fill < total_next) begin
            state_next = lfd_pkg::ST_IDLE;
          end else begin
            off_next   = '0;
            state_next = lfd_pkg::ST_EMIT;
          end
        end
      end

      lfd_pkg::ST_EMIT: begin
        raddr = wrap_addr(head, off);
        if (advance) begin
          if (show) begin
            load_out       = 1'b1;
            out_valid_next = 1'b1;
            res_cnt_next   = res_cnt + lfd_pkg::RES_W'(1);
          end
          if (last_byte) begin
            // frame out: drop it from the store and reparse
            head_next  = wrap_addr(head, total);
            fill_next  = fill - total;
            off_next   = '0;
            state_next = lfd_pkg::ST_P0;
          end else begin
            off_next = off + CW'(1);
            raddr    = wrap_addr(head, off + CW'(1));
          end
        end
      end

      lfd_pkg::ST_RSYNC: begin
        if (fill <= CW'(1)) begin
          fill_next  = '0;
          state_next = lfd_pkg::ST_P0;
        end else begin
          off_next   = CW'(1);
          raddr      = wrap_addr(head, CW'(1));
          state_next = lfd_pkg::ST_SCAN;
        end
      end

      lfd_pkg::ST_SCAN: begin
        if (rdata == sync_first) begin
          head_next  = wrap_addr(head, off);
          fill_next  = fill - off;
          state_next = lfd_pkg::ST_P0;
        end else if ((off + CW'(1)) >= fill) begin
          fill_next  = '0;
          state_next = lfd_pkg::ST_P0;
        end else begin
          off_next = off + CW'(1);
          raddr    = wrap_addr(head, off + CW'(1));
        end
      end

      default: begin
        state_next = lfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lfd_pkg::ST_IDLE;
      head        <= '0;
      fill        <= '0;
      idle_ticks  <= 8'd0;
      off         <= '0;
      res_cnt     <= '0;
      out_valid   <= 1'b0;
      sync_first  <= lfd_pkg::SYNC_FIRST_RST;
      sync_second <= lfd_pkg::SYNC_SECOND_RST;
      stall_ticks <= lfd_pkg::STALL_TICKS_RST;
    end else begin
      state      <= state_next;
      head       <= head_next;
      fill       <= fill_next;
      idle_ticks <= idle_ticks_next;
      off        <= off_next;
      res_cnt    <= res_cnt_next;
      out_valid  <= out_valid_next;
      if (cfg_write) begin
        unique case (cfg_index)
          lfd_pkg::CFG_SYNC_FIRST:  sync_first  <= cfg_data;
          lfd_pkg::CFG_SYNC_SECOND: sync_second <= cfg_data;
          lfd_pkg::CFG_STALL_TICKS: stall_ticks <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    total  <= total_next;
    plen6  <= plen6_next;
    len_hi <= len_hi_next;
    if (load_out) begin
      frame_byte     <= rdata;
      frame_last     <= last_byte;
      payload_length <= plen6;
    end
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= q_cmd.data;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/length_framed_deframer_with_resync.sv]
// Deframer for a byte stream of frames: two sync bytes, a big-endian 16-bit
// payload length, then the payload.
// Input channel (in_valid / in_stall): op 0 carries a received byte in
// rx_byte, op 1 is one timer tick. A two-entry command queue sits in front
// of the parse engine, so up to two transfers are taken while it is busy.
// Output channel (out_valid / out_stall): one transfer per frame byte,
// header included, frame_last on the final byte, payload_length with each.
// Configuration (cfg_write, cfg_index, cfg_data): sync_first, sync_second and
// stall_ticks; write only while the block is idle.
// Each item runs through the parse sequencer, which reads the store one
// byte per cycle while the output is not stalled. A resync scans the stored
// bytes for sync_first; a complete frame is emitted byte by byte. At most
// 64 frame bytes are output per queued command; the rest are dropped.
// When out_stall is high on a valid output byte, the output register holds
// it and the sequencer waits; the input queue keeps taking transfers until full.
// Reset (rst, synchronous) empties the store and queue and restores the
// register defaults; the store contents need no clearing.
module length_framed_deframer_with_resync #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic       frame_last,
  output logic [5:0] payload_length
);

  logic          q_valid;
  lfd_pkg::cmd_t q_cmd;
  logic          q_pop;

  lfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  lfd_engine #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_byte     (frame_byte),
    .frame_last     (frame_last),
    .payload_length (payload_length)
  );

endmodule
